// ===== hw/rtl/psi_pkg.sv =====
// ----------------------------------------------------------------------------
// psi_pkg
// Shared types and constants for the power series inverse block.
// ----------------------------------------------------------------------------
package psi_pkg;

	localparam int MAX_TERMS = 32;
	localparam int COEFF_W   = 31;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int STEP_W    = $clog2(COEFF_W);
	localparam int LVL_W     = 3;
	localparam int TT_W      = 6;

	typedef logic [COEFF_W-1:0] coeff_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef enum logic [0:0] {
		REG_MODULUS = 1'b0,
		REG_TARGET  = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH_IN,
		OP_RED_START,
		OP_SER_WRITE,
		OP_EU_INIT,
		OP_DIV_START,
		OP_EU_MUL_START,
		OP_EU_STEP,
		OP_NW_INIT,
		OP_CV_READ,
		OP_CV_MUL_START,
		OP_CV_ACC,
		OP_CV_WRITE,
		OP_PHASE2,
		OP_LEVEL_NEXT,
		OP_OUT_READ,
		OP_OUT_LOAD,
		OP_OUT_FAIL,
		OP_CLEAR
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD_CHK,
		ST_RED_WAIT,
		ST_SER_WR,
		ST_EU_INIT,
		ST_EU_TEST,
		ST_EU_DIV_WAIT,
		ST_EU_MUL,
		ST_EU_MUL_WAIT,
		ST_EU_STEP,
		ST_EU_END,
		ST_CV_READ,
		ST_CV_MUL,
		ST_CV_WAIT,
		ST_CV_ACC,
		ST_CV_WRITE,
		ST_LVL_END,
		ST_OUT_READ,
		ST_OUT_WAIT,
		ST_FAIL,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic load_full;
		logic last;
		logic r1_zero;
		logic r0_one;
		logic mul_done;
		logic div_done;
		logic j_end;
		logic i_end;
		logic phase;
		logic k_zero;
		logic no_levels;
		logic out_full;
		logic out_last;
	} status_t;

	// number of doubling levels, ceil(log2(n)) for n in 1..MAX_TERMS
	function automatic logic [LVL_W-1:0] level_count(input cnt_t n);
		logic [LVL_W-1:0] l;
		l = '0;
		for (int s = 0; s < IDX_W; s++) begin
			if ({1'b0, n} > (CNT_W+1)'(1 << s))
				l = LVL_W'(s + 1);
		end
		return l;
	endfunction

endpackage

// ===== hw/rtl/psi_mulmod.sv =====
// ----------------------------------------------------------------------------
// psi_mulmod
// Bit-serial modular multiplier, (a * b) mod p, one bit of b per cycle.
// ----------------------------------------------------------------------------
module psi_mulmod import psi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  coeff_t a,
	input  coeff_t b,
	input  coeff_t p,
	output logic   done,
	output coeff_t res
);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	coeff_t            a_q, b_q, p_q, r_q;
	logic [COEFF_W:0]  dbl, t1, t2, t3, pe;

	// a < p on entry, so each step needs two conditional subtracts
	always_comb begin
		pe  = {1'b0, p_q};
		dbl = {r_q, 1'b0};
		t1  = (dbl >= pe) ? dbl - pe : dbl;
		t2  = t1 + (b_q[COEFF_W-1] ? {1'b0, a_q} : '0);
		t3  = (t2 >= pe) ? t2 - pe : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(COEFF_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= p;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= t3[COEFF_W-1:0];
			b_q <= {b_q[COEFF_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

// ===== hw/rtl/psi_divider.sv =====
// ----------------------------------------------------------------------------
// psi_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psi_divider import psi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  coeff_t num,
	input  coeff_t den,
	output logic   done,
	output coeff_t quo,
	output coeff_t rem
);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	coeff_t            num_q, den_q, rem_q;
	logic [COEFF_W:0]  sh, de, nr;
	logic              ge;

	always_comb begin
		sh = {rem_q, num_q[COEFF_W-1]};
		de = {1'b0, den_q};
		ge = (sh >= de);
		nr = ge ? sh - de : sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(COEFF_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= nr[COEFF_W-1:0];
			num_q <= {num_q[COEFF_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/psi_datapath.sv =====
// ----------------------------------------------------------------------------
// psi_datapath
// Coefficient stores, Euclid registers, convolution counters and output
// register; executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module psi_datapath import psi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             st,
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [COEFF_W-1:0]  cfg_data,
	input  logic                in_valid,
	input  coeff_t              in_coeff,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output coeff_t              out_coeff,
	output logic                out_last,
	output logic                out_status
);

	coeff_t            modulus_q;
	logic [TT_W-1:0]   tterms_q;
	coeff_t            p_eff, two_mod;
	cnt_t              n;
	logic [LVL_W-1:0]  nlev;

	coeff_t            coeff_q;
	logic              last_q;
	cnt_t              lcount_q;
	coeff_t            series_q [MAX_TERMS];
	coeff_t            corr_q   [MAX_TERMS];
	coeff_t            inv_mem  [2*MAX_TERMS];
	coeff_t            inv_rd_q, b_q;
	coeff_t            r0_q, r1_q, x0_q, x1_q, acc_q;
	idx_t              i_q, j_q, ij;
	cnt_t              cur_q, m_c;
	logic [LVL_W-1:0]  k_q;
	logic              bank_q, phase_q;
	logic              out_valid_q, out_last_q, out_status_q;
	coeff_t            out_coeff_q;

	logic              mul_start, mul_done, div_done;
	coeff_t            mul_a, mul_b, mul_res, quo, rem;
	logic [COEFF_W:0]  xt, acc_sum, v_neg, v_fix;
	logic [CNT_W:0]    m_wide;
	logic              rd_en;
	logic [IDX_W:0]    rd_addr;

	always_comb begin
		p_eff   = (modulus_q < COEFF_W'(2)) ? COEFF_W'(2) : modulus_q;
		two_mod = (p_eff == COEFF_W'(2)) ? '0 : COEFF_W'(2);
		if (tterms_q == '0)
			n = CNT_W'(1);
		else if (tterms_q > TT_W'(MAX_TERMS))
			n = CNT_W'(MAX_TERMS);
		else
			n = CNT_W'(tterms_q);
		nlev   = level_count(n);
		m_wide = ({1'b0, n} + ((CNT_W+1)'(1) << k_q) - (CNT_W+1)'(1)) >> k_q;
		m_c    = m_wide[CNT_W-1:0];
		ij     = i_q - j_q;
	end

	always_comb begin
		case (cmd.op)
			OP_RED_START: begin
				mul_a = COEFF_W'(1);
				mul_b = coeff_q;
			end
			OP_EU_MUL_START: begin
				mul_a = x1_q;
				mul_b = quo;
			end
			default: begin
				mul_a = inv_rd_q;
				mul_b = b_q;
			end
		endcase
		mul_start = (cmd.op == OP_RED_START) || (cmd.op == OP_EU_MUL_START) ||
			(cmd.op == OP_CV_MUL_START);
	end

	psi_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (p_eff),
		.done   (mul_done),
		.res    (mul_res)
	);

	psi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_START),
		.num    (r0_q),
		.den    (r1_q),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	always_comb begin
		xt      = (x0_q >= mul_res) ? {1'b0, x0_q - mul_res}
			: {1'b0, x0_q} + {1'b0, p_eff} - {1'b0, mul_res};
		acc_sum = {1'b0, acc_q} + {1'b0, mul_res};
		if (acc_sum >= {1'b0, p_eff})
			acc_sum = acc_sum - {1'b0, p_eff};
		v_neg   = (acc_q == '0) ? '0 : {1'b0, p_eff} - {1'b0, acc_q};
		v_fix   = v_neg;
		if (i_q == '0) begin
			v_fix = v_neg + {1'b0, two_mod};
			if (v_fix >= {1'b0, p_eff})
				v_fix = v_fix - {1'b0, p_eff};
		end
		rd_en   = (cmd.op == OP_CV_READ) || (cmd.op == OP_OUT_READ);
		rd_addr = {bank_q, (cmd.op == OP_OUT_READ) ? i_q : j_q};
	end

	// inverse store, two banks of MAX_TERMS; a run starts in bank 0
	always_ff @(posedge clk) begin
		if (cmd.op == OP_NW_INIT)
			inv_mem[{1'b0, IDX_W'(0)}] <= x0_q;
		else if (cmd.op == OP_CV_WRITE && phase_q)
			inv_mem[{~bank_q, i_q}] <= acc_q;
		if (rd_en)
			inv_rd_q <= inv_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= COEFF_W'(2);
			tterms_q     <= TT_W'(1);
			lcount_q     <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int e = 0; e < MAX_TERMS; e++)
				series_q[e] <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_MODULUS: modulus_q <= cfg_data;
					REG_TARGET:  tterms_q  <= cfg_data[TT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.in_ready && in_valid)
				last_q <= in_last;
			if (cmd.op == OP_SER_WRITE) begin
				series_q[lcount_q[IDX_W-1:0]] <= mul_res;
				lcount_q <= lcount_q + 1'b1;
			end
			if (cmd.op == OP_CLEAR) begin
				lcount_q <= '0;
				for (int e = 0; e < MAX_TERMS; e++)
					series_q[e] <= '0;
			end
			if (cmd.op == OP_OUT_LOAD || cmd.op == OP_OUT_FAIL)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ready && in_valid)
			coeff_q <= in_coeff;
		case (cmd.op)
			OP_EU_INIT: begin
				r0_q <= p_eff;
				r1_q <= series_q[0];
				x0_q <= '0;
				x1_q <= COEFF_W'(1);
			end
			OP_EU_STEP: begin
				r0_q <= r1_q;
				r1_q <= rem;
				x0_q <= x1_q;
				x1_q <= xt[COEFF_W-1:0];
			end
			OP_NW_INIT: begin
				k_q     <= (nlev == '0) ? '0 : nlev - 1'b1;
				cur_q   <= CNT_W'(1);
				bank_q  <= 1'b0;
				i_q     <= '0;
				j_q     <= '0;
				acc_q   <= '0;
				phase_q <= 1'b0;
			end
			OP_CV_READ:
				b_q <= phase_q ? corr_q[ij] : series_q[ij];
			OP_CV_ACC: begin
				acc_q <= acc_sum[COEFF_W-1:0];
				j_q   <= j_q + 1'b1;
			end
			OP_CV_WRITE: begin
				if (!phase_q)
					corr_q[i_q] <= v_fix[COEFF_W-1:0];
				i_q   <= i_q + 1'b1;
				j_q   <= '0;
				acc_q <= '0;
			end
			OP_PHASE2: begin
				phase_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
				acc_q   <= '0;
			end
			OP_LEVEL_NEXT: begin
				bank_q  <= ~bank_q;
				cur_q   <= m_c;
				if (k_q != '0)
					k_q <= k_q - 1'b1;
				phase_q <= 1'b0;
				i_q     <= '0;
				j_q     <= '0;
				acc_q   <= '0;
			end
			OP_OUT_LOAD: begin
				out_coeff_q  <= inv_rd_q;
				out_last_q   <= ({1'b0, i_q} + 1'b1 == n);
				out_status_q <= 1'b0;
				i_q          <= i_q + 1'b1;
			end
			OP_OUT_FAIL: begin
				out_coeff_q  <= '0;
				out_last_q   <= 1'b1;
				out_status_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		st.load_full = (lcount_q >= CNT_W'(MAX_TERMS));
		st.last      = last_q;
		st.r1_zero   = (r1_q == '0);
		st.r0_one    = (r0_q == COEFF_W'(1));
		st.mul_done  = mul_done;
		st.div_done  = div_done;
		st.j_end     = (j_q == i_q) || ({1'b0, j_q} + 1'b1 == cur_q);
		st.i_end     = ({1'b0, i_q} + 1'b1 == m_c);
		st.phase     = phase_q;
		st.k_zero    = (k_q == '0);
		st.no_levels = (nlev == '0);
		st.out_full  = out_valid_q;
		st.out_last  = ({1'b0, i_q} + 1'b1 == n);
	end

	assign out_valid  = out_valid_q;
	assign out_coeff  = out_coeff_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule

// ===== hw/rtl/psi_ctrl.sv =====
// ----------------------------------------------------------------------------
// psi_ctrl
// Sequencer: load, constant term inverse, Newton levels, result output.
// ----------------------------------------------------------------------------
module psi_ctrl import psi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LATCH_IN;
					state_d = ST_LOAD_CHK;
				end
			end
			ST_LOAD_CHK: begin
				if (!st.load_full) begin
					cmd.op  = OP_RED_START;
					state_d = ST_RED_WAIT;
				end else if (st.last)
					state_d = ST_EU_INIT;
				else
					state_d = ST_IDLE;
			end
			ST_RED_WAIT:
				if (st.mul_done)
					state_d = ST_SER_WR;
			ST_SER_WR: begin
				cmd.op  = OP_SER_WRITE;
				state_d = st.last ? ST_EU_INIT : ST_IDLE;
			end
			ST_EU_INIT: begin
				cmd.op  = OP_EU_INIT;
				state_d = ST_EU_TEST;
			end
			ST_EU_TEST: begin
				if (st.r1_zero)
					state_d = ST_EU_END;
				else begin
					cmd.op  = OP_DIV_START;
					state_d = ST_EU_DIV_WAIT;
				end
			end
			ST_EU_DIV_WAIT:
				if (st.div_done)
					state_d = ST_EU_MUL;
			ST_EU_MUL: begin
				cmd.op  = OP_EU_MUL_START;
				state_d = ST_EU_MUL_WAIT;
			end
			ST_EU_MUL_WAIT:
				if (st.mul_done)
					state_d = ST_EU_STEP;
			ST_EU_STEP: begin
				cmd.op  = OP_EU_STEP;
				state_d = ST_EU_TEST;
			end
			ST_EU_END: begin
				if (st.r0_one) begin
					cmd.op  = OP_NW_INIT;
					state_d = st.no_levels ? ST_OUT_READ : ST_CV_READ;
				end else
					state_d = ST_FAIL;
			end
			ST_CV_READ: begin
				cmd.op  = OP_CV_READ;
				state_d = ST_CV_MUL;
			end
			ST_CV_MUL: begin
				cmd.op  = OP_CV_MUL_START;
				state_d = ST_CV_WAIT;
			end
			ST_CV_WAIT:
				if (st.mul_done)
					state_d = ST_CV_ACC;
			ST_CV_ACC: begin
				cmd.op  = OP_CV_ACC;
				state_d = st.j_end ? ST_CV_WRITE : ST_CV_READ;
			end
			ST_CV_WRITE: begin
				cmd.op  = OP_CV_WRITE;
				state_d = st.i_end ? ST_LVL_END : ST_CV_READ;
			end
			ST_LVL_END: begin
				if (!st.phase) begin
					cmd.op  = OP_PHASE2;
					state_d = ST_CV_READ;
				end else begin
					cmd.op  = OP_LEVEL_NEXT;
					state_d = st.k_zero ? ST_OUT_READ : ST_CV_READ;
				end
			end
			ST_OUT_READ: begin
				cmd.op  = OP_OUT_READ;
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT:
				if (!st.out_full) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = st.out_last ? ST_CLEAR : ST_OUT_READ;
				end
			ST_FAIL:
				if (!st.out_full) begin
					cmd.op  = OP_OUT_FAIL;
					state_d = ST_CLEAR;
				end
			ST_CLEAR: begin
				cmd.op  = OP_CLEAR;
				state_d = ST_IDLE;
			end
			default:
				state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/power_series_inverse_mod_p_top.sv =====
// ----------------------------------------------------------------------------
// power_series_inverse_mod_p_top
// Inverse of a power series modulo X^n over the integers modulo p.
// ----------------------------------------------------------------------------
// Coefficients enter lowest degree first, one per transfer, the run closed by
// tlast; each is reduced by the 31-step bit-serial modular multiplier before
// the next is taken. After the last one the constant term is inverted by
// extended Euclid, each remainder step running the divider then the
// multiplier, then each Newton level computes its product terms, all on the
// one shared multiplier. Results leave one per transfer, lowest term first,
// with tlast on the final one and tuser set on a lone not-invertible result.
// No new coefficient is taken until the run's last result is loaded.
// ----------------------------------------------------------------------------
module power_series_inverse_mod_p_top import psi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [30:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] coeff_in, [31] zero
	input  logic        s_axis_tlast,   // last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [30:0] coeff_out, [31] zero
	output logic        m_axis_tlast,   // last_out
	output logic        m_axis_tuser    // status
);

	cmd_t    cmd;
	status_t st;
	coeff_t  out_coeff;

	psi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.st       (st),
		.cmd      (cmd)
	);

	psi_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_coeff   (s_axis_tdata[COEFF_W-1:0]),
		.in_last    (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_coeff  (out_coeff),
		.out_last   (m_axis_tlast),
		.out_status (m_axis_tuser)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = {1'b0, out_coeff};

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 32'd0)
		else $error("not-invertible result without tlast or with data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT_LOAD || cmd.op == OP_OUT_FAIL |-> !m_axis_tvalid)
		else $error("result register loaded while still pending");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT_LOAD || cmd.op == OP_OUT_FAIL |=> m_axis_tvalid)
		else $error("loaded result not presented");

	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken in the middle of a result run");

endmodule
